// ----- rtl/sip_pkg.sv -----
package sip_pkg;

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DEN_W      = PROD_W + 1;
    localparam int NUM_W      = DEN_W + DIFF_W + 1;
    localparam int Q_W        = COORD_W + 1;
    localparam int MIDQ_DEPTH = 8;
    localparam int OUTQ_DEPTH = 32;

    typedef enum logic [1:0] {
        STAT_HIT      = 2'd0,
        STAT_PARALLEL = 2'd1,
        STAT_MISS     = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_start_x;
        logic signed [COORD_W-1:0] a_start_y;
        logic signed [COORD_W-1:0] a_end_x;
        logic signed [COORD_W-1:0] a_end_y;
        logic signed [COORD_W-1:0] b_start_x;
        logic signed [COORD_W-1:0] b_start_y;
        logic signed [COORD_W-1:0] b_end_x;
        logic signed [COORD_W-1:0] b_end_y;
    } item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [COORD_W-1:0] cross_x;
        logic signed [COORD_W-1:0] cross_y;
    } result_t;

    // classified request handed from front to back
    typedef struct packed {
        status_t                   status;
        logic signed [DEN_W-1:0]   den;
        logic signed [DEN_W-1:0]   tn;
        logic signed [DIFF_W-1:0]  eax;
        logic signed [DIFF_W-1:0]  eay;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
    } mid_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [DIFF_W-1:0]  eax;
        logic signed [DIFF_W-1:0]  eay;
        logic signed [DIFF_W-1:0]  ebx;
        logic signed [DIFF_W-1:0]  eby;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
    } f1_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [DIFF_W-1:0]  eax;
        logic signed [DIFF_W-1:0]  eay;
        logic signed [PROD_W-1:0]  p_ab;
        logic signed [PROD_W-1:0]  p_ba;
        logic signed [PROD_W-1:0]  p_sa;
        logic signed [PROD_W-1:0]  p_sb;
        logic signed [PROD_W-1:0]  p_ta;
        logic signed [PROD_W-1:0]  p_tb;
    } f2_t;

    typedef struct packed {
        status_t                          status;
        logic signed [DEN_W-1:0]          den;
        logic signed [COORD_W+DEN_W-1:0]  pxa;
        logic signed [DEN_W+DIFF_W-1:0]   pxb;
        logic signed [COORD_W+DEN_W-1:0]  pya;
        logic signed [DEN_W+DIFF_W-1:0]   pyb;
    } b1_t;

    typedef struct packed {
        status_t                 status;
        logic signed [DEN_W-1:0] den;
        logic signed [NUM_W-1:0] num_x;
        logic signed [NUM_W-1:0] num_y;
    } b2_t;

    typedef struct packed {
        status_t          status;
        logic [DEN_W-1:0] dmag;
        logic             neg_x;
        logic             neg_y;
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [Q_W-1:0]   q_x;
        logic [Q_W-1:0]   q_y;
    } div_t;

endpackage

// ----- rtl/sip_front.sv -----
module sip_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  sip_pkg::item_t item,
    output logic           mq_push,
    output sip_pkg::mid_t  mq_data,
    input  logic           mq_pop
);
    import sip_pkg::*;

    localparam int CNT_W = $clog2(MIDQ_DEPTH + 1);

    logic [CNT_W-1:0] res_reg, res_next;
    logic             acc;
    logic             v1_reg, v2_reg, v3_reg;
    f1_t              f1_reg, f1_next;
    f2_t              f2_reg, f2_next;
    mid_t             m_reg, m_next;

    // every request in flight owns a queue slot, so the queue never overflows
    assign full = (res_reg == CNT_W'(MIDQ_DEPTH));
    assign acc  = push && !full;

    always_comb
    begin
        res_next = res_reg + CNT_W'(acc) - CNT_W'(mq_pop);
    end

    always_comb
    begin
        f1_next.ox  = item.a_start_x;
        f1_next.oy  = item.a_start_y;
        f1_next.eax = DIFF_W'(item.a_end_x) - DIFF_W'(item.a_start_x);
        f1_next.eay = DIFF_W'(item.a_end_y) - DIFF_W'(item.a_start_y);
        f1_next.ebx = DIFF_W'(item.b_end_x) - DIFF_W'(item.b_start_x);
        f1_next.eby = DIFF_W'(item.b_end_y) - DIFF_W'(item.b_start_y);
        f1_next.dx  = DIFF_W'(item.a_start_x) - DIFF_W'(item.b_start_x);
        f1_next.dy  = DIFF_W'(item.a_start_y) - DIFF_W'(item.b_start_y);
    end

    always_comb
    begin
        f2_next.ox   = f1_reg.ox;
        f2_next.oy   = f1_reg.oy;
        f2_next.eax  = f1_reg.eax;
        f2_next.eay  = f1_reg.eay;
        f2_next.p_ab = $signed(f1_reg.eax) * $signed(f1_reg.eby);
        f2_next.p_ba = $signed(f1_reg.ebx) * $signed(f1_reg.eay);
        f2_next.p_sa = $signed(f1_reg.eax) * $signed(f1_reg.dy);
        f2_next.p_sb = $signed(f1_reg.eay) * $signed(f1_reg.dx);
        f2_next.p_ta = $signed(f1_reg.ebx) * $signed(f1_reg.dy);
        f2_next.p_tb = $signed(f1_reg.eby) * $signed(f1_reg.dx);
    end

    always_comb
    begin
        logic signed [DEN_W-1:0] den;
        logic signed [DEN_W-1:0] sn;
        logic signed [DEN_W-1:0] tn;
        logic                    pos;
        logic                    miss;
        den  = DEN_W'($signed(f2_reg.p_ab)) - DEN_W'($signed(f2_reg.p_ba));
        sn   = DEN_W'($signed(f2_reg.p_sa)) - DEN_W'($signed(f2_reg.p_sb));
        tn   = DEN_W'($signed(f2_reg.p_ta)) - DEN_W'($signed(f2_reg.p_tb));
        pos  = !den[DEN_W-1];
        // closed range [0, den] for positive den, open (den, 0) for negative
        miss = ((sn < 0) == pos) || ((tn < 0) == pos) ||
               ((sn > den) == pos) || ((tn > den) == pos);
        m_next.den = den;
        m_next.tn  = tn;
        m_next.eax = f2_reg.eax;
        m_next.eay = f2_reg.eay;
        m_next.ox  = f2_reg.ox;
        m_next.oy  = f2_reg.oy;
        if (den == '0)
        begin
            m_next.status = STAT_PARALLEL;
        end
        else if (miss)
        begin
            m_next.status = STAT_MISS;
        end
        else
        begin
            m_next.status = STAT_HIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            res_reg <= res_next;
            v1_reg  <= acc;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg <= f1_next;
        f2_reg <= f2_next;
        m_reg  <= m_next;
    end

    assign mq_push = v3_reg;
    assign mq_data = m_reg;

endmodule

// ----- rtl/sip_mid_fifo.sv -----
module sip_mid_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sip_pkg::mid_t wr_data,
    input  logic          rd_en,
    output sip_pkg::mid_t rd_data,
    output logic          empty
);
    import sip_pkg::*;

    localparam int PTR_W = $clog2(MIDQ_DEPTH);
    localparam int CNT_W = $clog2(MIDQ_DEPTH + 1);

    mid_t             mem_reg [MIDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(wr_en);
        rd_ptr_next = rd_ptr_reg + PTR_W'(rd_en);
        cnt_next    = cnt_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/sip_back.sv -----
module sip_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sip_pkg::mid_t    mq_data,
    input  logic             mq_empty,
    output logic             mq_pop,
    output logic             empty,
    input  logic             pop,
    output sip_pkg::result_t result
);
    import sip_pkg::*;

    localparam int RES_W = $clog2(OUTQ_DEPTH + 1);
    localparam int PTR_W = $clog2(OUTQ_DEPTH);

    logic [RES_W-1:0] res_reg, res_next;
    logic             issue, pop_acc;
    logic             v1_reg, v2_reg, vf_reg;
    b1_t              b1_reg, b1_next;
    b2_t              b2_reg, b2_next;
    div_t             d0_next;
    div_t             dv_reg [Q_W+1];
    logic             dv_v_reg [Q_W+1];
    result_t          fin_reg, fin_next;

    result_t          oq_reg [OUTQ_DEPTH];
    logic [PTR_W-1:0] oq_wr_reg, oq_rd_reg;
    logic [RES_W-1:0] oq_cnt_reg, oq_cnt_next;

    // take a request only when an output slot is reserved for it
    assign issue   = !mq_empty && (res_reg < RES_W'(OUTQ_DEPTH));
    assign mq_pop  = issue;
    assign pop_acc = pop && !empty;
    assign empty   = (oq_cnt_reg == '0);
    assign result  = oq_reg[oq_rd_reg];

    always_comb
    begin
        res_next    = res_reg + RES_W'(issue) - RES_W'(pop_acc);
        oq_cnt_next = oq_cnt_reg + RES_W'(vf_reg) - RES_W'(pop_acc);
    end

    always_comb
    begin
        b1_next.status = mq_data.status;
        b1_next.den    = mq_data.den;
        b1_next.pxa    = $signed(mq_data.ox) * $signed(mq_data.den);
        b1_next.pxb    = $signed(mq_data.tn) * $signed(mq_data.eax);
        b1_next.pya    = $signed(mq_data.oy) * $signed(mq_data.den);
        b1_next.pyb    = $signed(mq_data.tn) * $signed(mq_data.eay);
    end

    always_comb
    begin
        b2_next.status = b1_reg.status;
        b2_next.den    = b1_reg.den;
        b2_next.num_x  = NUM_W'($signed(b1_reg.pxa)) + NUM_W'($signed(b1_reg.pxb));
        b2_next.num_y  = NUM_W'($signed(b1_reg.pya)) + NUM_W'($signed(b1_reg.pyb));
    end

    // take magnitudes; the quotient sign is restored after the divider
    always_comb
    begin
        logic dneg;
        dneg            = b2_reg.den[DEN_W-1];
        d0_next.status  = b2_reg.status;
        d0_next.dmag    = dneg ? DEN_W'(-b2_reg.den) : DEN_W'(b2_reg.den);
        d0_next.neg_x   = b2_reg.num_x[NUM_W-1] ^ dneg;
        d0_next.neg_y   = b2_reg.num_y[NUM_W-1] ^ dneg;
        d0_next.rem_x   = b2_reg.num_x[NUM_W-1] ? NUM_W'(-b2_reg.num_x)
                                                : NUM_W'(b2_reg.num_x);
        d0_next.rem_y   = b2_reg.num_y[NUM_W-1] ? NUM_W'(-b2_reg.num_y)
                                                : NUM_W'(b2_reg.num_y);
        d0_next.q_x     = '0;
        d0_next.q_y     = '0;
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0] <= d0_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else
        begin
            dv_v_reg[0] <= v2_reg;
        end
    end

    // restoring divider, one quotient bit per stage, most significant first
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        localparam int BIT = Q_W - 1 - k;
        div_t d_next;

        always_comb
        begin
            logic [NUM_W-1:0] sub;
            sub    = NUM_W'(dv_reg[k].dmag) << BIT;
            d_next = dv_reg[k];
            if (dv_reg[k].rem_x >= sub)
            begin
                d_next.rem_x    = dv_reg[k].rem_x - sub;
                d_next.q_x[BIT] = 1'b1;
            end
            if (dv_reg[k].rem_y >= sub)
            begin
                d_next.rem_y    = dv_reg[k].rem_y - sub;
                d_next.q_y[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[k+1] <= d_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end
    end

    always_comb
    begin
        logic [Q_W-1:0] qx;
        logic [Q_W-1:0] qy;
        qx = dv_reg[Q_W].neg_x ? Q_W'(-dv_reg[Q_W].q_x) : dv_reg[Q_W].q_x;
        qy = dv_reg[Q_W].neg_y ? Q_W'(-dv_reg[Q_W].q_y) : dv_reg[Q_W].q_y;
        fin_next.status = dv_reg[Q_W].status;
        if (dv_reg[Q_W].status == STAT_HIT)
        begin
            fin_next.cross_x = qx[COORD_W-1:0];
            fin_next.cross_y = qy[COORD_W-1:0];
        end
        else
        begin
            fin_next.cross_x = '0;
            fin_next.cross_y = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg    <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            vf_reg     <= 1'b0;
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            res_reg    <= res_next;
            v1_reg     <= issue;
            v2_reg     <= v1_reg;
            vf_reg     <= dv_v_reg[Q_W];
            oq_wr_reg  <= oq_wr_reg + PTR_W'(vf_reg);
            oq_rd_reg  <= oq_rd_reg + PTR_W'(pop_acc);
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg  <= b1_next;
        b2_reg  <= b2_next;
        fin_reg <= fin_next;
        if (vf_reg)
        begin
            oq_reg[oq_wr_reg] <= fin_reg;
        end
    end

endmodule

// ----- rtl/segment_intersection_point_top.sv -----
// Segment intersection: each request carries two signed 16-bit segments, A and B,
// and yields one result with status (0 crossing, 1 parallel or collinear, 2 no
// crossing) and the crossing point on A, computed exactly and truncated toward
// zero; the point is zero unless status is 0. Requests are pushed while full is
// low and results popped while empty is low, oldest first. One request is taken
// per cycle while full is low; a request passes the front stages and the mid queue
// write, then the back stages with the bit-per-stage divider, before its result is
// shown. The output queue holds 32 results; when it stops draining the block keeps
// taking requests until the 8-entry mid queue and the reserved output slots are
// used up.
module segment_intersection_point_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  sip_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output sip_pkg::result_t result
);
    import sip_pkg::*;

    logic mq_push, mq_pop, mq_empty;
    mid_t mq_wdata, mq_rdata;

    // front: edge differences, cross products, classify
    sip_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .mq_push (mq_push),
        .mq_data (mq_wdata),
        .mq_pop  (mq_pop)
    );

    // hold classified requests between the two halves
    sip_mid_fifo u_mid (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mq_push),
        .wr_data (mq_wdata),
        .rd_en   (mq_pop),
        .rd_data (mq_rdata),
        .empty   (mq_empty)
    );

    // back: numerators, exact division, output queue
    sip_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .mq_data  (mq_rdata),
        .mq_empty (mq_empty),
        .mq_pop   (mq_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

// ----- rtl/sip_checker.sv -----
module sip_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input sip_pkg::result_t result
);
    import sip_pkg::*;

    // no result may be shown right after reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown after reset");

    // input must be open right after reset
    a_reset_full: assert property (@(posedge clk) !rst_n |=> !full)
        else $error("full right after reset");

    // a shown result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed before pop");

    // point is zero on every non-crossing status
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.status != STAT_HIT |-> result.cross_x == '0 && result.cross_y == '0)
        else $error("nonzero point without crossing");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.status == STAT_HIT || result.status == STAT_PARALLEL ||
                   result.status == STAT_MISS)
        else $error("undefined status code");

endmodule

bind segment_intersection_point_top sip_checker u_sip_checker (.*);

// ----- tb/segment_intersection_point_top_tb.sv -----
`timescale 1ns / 1ps

module segment_intersection_point_top_tb;

    import sip_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;

    segment_intersection_point_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Requests waiting to be driven, and the results predicted for accepted ones.
    item_t   pending_reqs[$];
    result_t expected_results[$];

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned pop_hold;      // long receiver hold-off, counted down in its own block
    bit          pause_send;    // sender waits for the pipeline to drain
    bit          stim_done;
    int unsigned send_gap;
    int unsigned recv_gap;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Exact crossing point: all products held at 80 bits, far more than needed.
    function automatic result_t predict_crossing(item_t req);
        result_t r;
        logic signed [79:0] ox, oy, eax, eay, ebx, eby, dx, dy;
        logic signed [79:0] den, sn, tn, nx, ny;
        bit dpos;
        begin
            ox  = req.a_start_x;
            oy  = req.a_start_y;
            eax = 80'(signed'(req.a_end_x)) - ox;
            eay = 80'(signed'(req.a_end_y)) - oy;
            ebx = 80'(signed'(req.b_end_x)) - 80'(signed'(req.b_start_x));
            eby = 80'(signed'(req.b_end_y)) - 80'(signed'(req.b_start_y));
            dx  = ox - 80'(signed'(req.b_start_x));
            dy  = oy - 80'(signed'(req.b_start_y));
            r.status  = STAT_HIT;
            r.cross_x = '0;
            r.cross_y = '0;
            den = eax * eby - ebx * eay;
            if (den == 0)
            begin
                r.status = STAT_PARALLEL;
                return r;
            end
            dpos = den > 0;
            sn = eax * dy - eay * dx;
            tn = ebx * dy - eby * dx;
            if ((sn < 0) == dpos || (tn < 0) == dpos ||
                (sn > den) == dpos || (tn > den) == dpos)
            begin
                r.status = STAT_MISS;
                return r;
            end
            // signed division in SystemVerilog truncates toward zero
            nx = ox * den + tn * eax;
            ny = oy * den + tn * eay;
            r.cross_x = 16'(nx / den);
            r.cross_y = 16'(ny / den);
            return r;
        end
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        begin
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
            error_count++;
        end
    endtask

    function automatic void queue_req(item_t req);
        begin
            pending_reqs = {pending_reqs, req};
        end
    endfunction

    function automatic int unsigned pick_gap();
        begin
            if ($urandom_range(0, 2) == 0)
                return 0;
            if ($urandom_range(0, 19) == 0)
                return $urandom_range(10, 40);
            return $urandom_range(0, 3);
        end
    endfunction

    function automatic logic [15:0] pick_coord();
        begin
            case ($urandom_range(0, 7))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'(signed'($urandom_range(0, 40)) - 20);
                3: return 16'($urandom_range(0, 2000)) - 16'd1000;
                default: return 16'($urandom);
            endcase
        end
    endfunction

    // Build a pair that tends to cross: B runs through a point near the middle of A.
    function automatic item_t crossing_pair();
        item_t req;
        int sx, sy, ex, ey, mx, my, vx, vy, span;
        begin
            span = ($urandom_range(0, 3) == 0) ? 16000 : 500;
            sx = $urandom_range(0, 2 * span) - span;
            sy = $urandom_range(0, 2 * span) - span;
            ex = $urandom_range(0, 2 * span) - span;
            ey = $urandom_range(0, 2 * span) - span;
            mx = (sx + ex) / 2;
            my = (sy + ey) / 2;
            vx = $urandom_range(0, 2 * span) - span;
            vy = $urandom_range(0, 2 * span) - span;
            req.a_start_x = 16'(sx);
            req.a_start_y = 16'(sy);
            req.a_end_x   = 16'(ex);
            req.a_end_y   = 16'(ey);
            req.b_start_x = 16'(mx - vx / 2);
            req.b_start_y = 16'(my - vy / 2);
            req.b_end_x   = 16'(mx + vx / 2 + $urandom_range(0, 1));
            req.b_end_y   = 16'(my + vy / 2);
            return req;
        end
    endfunction

    function automatic item_t make_item(int ax0, int ay0, int ax1, int ay1,
                                        int bx0, int by0, int bx1, int by1);
        item_t req;
        begin
            req.a_start_x = 16'(ax0);
            req.a_start_y = 16'(ay0);
            req.a_end_x   = 16'(ax1);
            req.a_end_y   = 16'(ay1);
            req.b_start_x = 16'(bx0);
            req.b_start_y = 16'(by0);
            req.b_end_x   = 16'(bx1);
            req.b_end_y   = 16'(by1);
            return req;
        end
    endfunction

    // Stimulus: directed cases first, then mostly crossing pairs with some noise.
    initial
    begin
        item_t req;
        stim_done  = 1'b0;
        pause_send = 1'b0;
        // plain crossing, negative denominator
        queue_req(make_item(0, 0, 10, 10, 0, 10, 10, 0));
        // same with B reversed: positive denominator
        queue_req(make_item(0, 0, 10, 10, 10, 0, 0, 10));
        // touching at an endpoint in both orientations
        queue_req(make_item(0, 0, 10, 0, 10, -5, 10, 5));
        queue_req(make_item(0, 0, 10, 0, 10, 5, 10, -5));
        queue_req(make_item(0, 0, 10, 0, 0, -5, 0, 5));
        // parallel, collinear, degenerate
        queue_req(make_item(0, 0, 10, 0, 0, 1, 10, 1));
        queue_req(make_item(0, 0, 10, 0, 5, 0, 20, 0));
        queue_req(make_item(3, 3, 3, 3, 3, 3, 3, 3));
        // miss: lines cross outside the segments
        queue_req(make_item(0, 0, 1, 1, 5, 0, 4, 1));
        // truncation toward zero of negative coordinates
        queue_req(make_item(-1, -1, -4, -2, -3, 0, -2, -3));
        queue_req(make_item(-7, 3, 2, -5, -6, -6, 1, 4));
        // extremes of the coordinate range
        queue_req(make_item(-32768, -32768, 32767, 32767,
                            -32768, 32767, 32767, -32768));
        queue_req(make_item(32767, -32768, -32768, 32767,
                            -32768, -32768, 32767, 32767));
        queue_req(make_item(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
        queue_req(make_item(32767, 32767, 32767, 32767,
                            -32768, -32768, -32768, -32768));
        queue_req(make_item(-32768, -32768, 32767, 32766,
                            32767, -32768, -32768, 32767));
        for (int i = 0; i < 1250; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                req.a_start_x = pick_coord();
                req.a_start_y = pick_coord();
                req.a_end_x   = pick_coord();
                req.a_end_y   = pick_coord();
                req.b_start_x = pick_coord();
                req.b_start_y = pick_coord();
                req.b_end_x   = pick_coord();
                req.b_end_y   = pick_coord();
            end
            else
                req = crossing_pair();
            queue_req(req);
        end
        stim_done = 1'b1;
    end

    // Driver: offer requests from the pending queue with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            item     <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (push && !full)
                expected_results = {expected_results, predict_crossing(item)};
            if (push && full)
            begin
                // hold the offered request until it is taken
            end
            else if (send_gap != 0)
            begin
                push     <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pause_send || pending_reqs.size() == 0)
                push <= 1'b0;
            else
            begin
                push     <= 1'b1;
                item     <= pending_reqs.pop_front();
                send_gap <= pick_gap();
            end
        end
    end

    // Monitor: pop results with random stalls and compare with predictions.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            pop      <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", result.status, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                    if (result.cross_x !== want.cross_x)
                        report_mismatch("cross_x", result.cross_x, want.cross_x);
                    if (result.cross_y !== want.cross_y)
                        report_mismatch("cross_y", result.cross_y, want.cross_y);
                end
            end
            if (pop_hold != 0)
                pop <= 1'b0;
            else if (recv_gap != 0)
            begin
                pop      <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                pop      <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // Long receiver hold-off, counted down here.
    always @(posedge clk)
    begin
        if (pop_hold != 0)
            pop_hold <= pop_hold - 1;
        else if (cycle_count == 1000)
            pop_hold <= 400;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        pop_hold    = 0;
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        item        = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;
        // let the sender pause once until everything in flight has come back
        while (cycle_count < 2000)
            @(posedge clk);
        @(posedge clk);
        pause_send <= 1'b1;
        @(posedge clk);
        while (push || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        pause_send <= 1'b0;
        // drain: all requests taken, all results in, then a little slack
        while (!stim_done || pending_reqs.size() != 0 || push)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
